// ----- sv/mvp_pkg.sv -----
package mvp_pkg;

  localparam logic [4:0] OmniChannel = 5'd16;

  localparam logic [1:0] RegListenChannel  = 2'd0;
  localparam logic [1:0] RegRealtimeEnable = 2'd1;
  localparam logic [1:0] RegVoiceEnable    = 2'd2;

  localparam logic [3:0] SystemNibble = 4'hf;

  typedef struct packed {
    logic       is_voice;
    logic [2:0] msg_type;
    logic [3:0] msg_channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } result_t;

  typedef struct packed {
    logic [7:0] running_status;
    logic [1:0] bytes_remaining;
    logic [6:0] data_hold;
  } parse_state_t;

  function automatic logic [1:0] msg_len(input logic [2:0] ty);
    logic [1:0] len;
    unique case (ty)
      3'd4, 3'd5: len = 2'd1;
      3'd7:       len = 2'd0;
      default:    len = 2'd2;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/mvp_decode.sv -----
module mvp_decode
  import mvp_pkg::*;
(
  input  logic [7:0]   midi_byte,
  input  parse_state_t state,
  input  logic [4:0]   listen_channel,
  input  logic [7:0]   realtime_enable,
  input  logic [6:0]   voice_enable,
  output parse_state_t state_next,
  output result_t      result,
  output logic         result_hit
);

  logic [2:0] voice_type;
  logic [1:0] remaining_dec;
  logic [7:0] voice_enable_ext;

  assign voice_type       = state.running_status[6:4];
  assign remaining_dec    = state.bytes_remaining - 2'd1;
  assign voice_enable_ext = {1'b0, voice_enable};

  always_comb begin
    state_next = state;
    result     = '0;
    result_hit = 1'b0;
    priority if (midi_byte[7:4] == SystemNibble) begin
      if (midi_byte[3]) begin
        result.msg_type = midi_byte[2:0];
        result_hit      = realtime_enable[midi_byte[2:0]];
      end else begin
        state_next.running_status = '0;
      end
    end else if (midi_byte[7]) begin
      if (listen_channel == OmniChannel || {1'b0, midi_byte[3:0]} == listen_channel) begin
        state_next.running_status  = midi_byte;
        state_next.bytes_remaining = msg_len(midi_byte[6:4]);
      end else begin
        state_next.running_status = '0;
      end
    end else if (state.running_status != 8'd0) begin
      state_next.bytes_remaining = remaining_dec;
      if (remaining_dec[0]) begin
        state_next.data_hold = midi_byte[6:0];
      end
      if (remaining_dec == 2'd0) begin
        state_next.bytes_remaining = msg_len(voice_type);
        result_hit           = voice_enable_ext[voice_type];
        result.is_voice      = 1'b1;
        result.msg_type      = voice_type;
        result.msg_channel   = state.running_status[3:0];
        if (msg_len(voice_type) == 2'd1) begin
          result.first_data  = midi_byte[6:0];
          result.second_data = '0;
        end else begin
          result.first_data  = state.data_hold;
          result.second_data = midi_byte[6:0];
        end
      end
    end else begin
      state_next = state;
    end
  end

endmodule

// ----- sv/midi_voice_message_parser_core.sv -----
// MIDI voice message parser with running status.
// Input channel: one raw MIDI byte per beat on midi_byte, qualified by
// in_valid and held off by in_stall. Output channel: one event per beat,
// either an enabled realtime byte or a completed, enabled voice message.
// Bytes that cause no event are consumed silently.
// Events are registered: an accepted byte's event is written into the output
// register, or into the skid register while the output register is stalled.
// Throughput is one byte per cycle while in_stall is low; the decode is a
// single pass of logic from the parse state to the output register.
// A two-entry output buffer (output register plus skid register) lets a
// byte be taken while an event waits; in_stall rises only when both are
// full, that is after the receiver has stalled an event and another one
// has been produced behind it.
// The APB port holds the listen channel, the realtime enables and the voice
// enables at byte addresses 0, 4 and 8. Writing the listen channel clears
// the running status. Reset selects omni mode, disables all events, clears
// the parse state and empties the output buffer.
module midi_voice_message_parser_core
  import mvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  midi_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_voice,
  output logic [2:0]  msg_type,
  output logic [3:0]  msg_channel,
  output logic [6:0]  first_data,
  output logic [6:0]  second_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]   listen_channel;
  logic [7:0]   realtime_enable;
  logic [6:0]   voice_enable;
  parse_state_t state;
  parse_state_t state_next;
  parse_state_t state_load;
  result_t      result;
  logic         result_hit;
  result_t      out_data;
  result_t      skid_data;
  logic         skid_valid;
  logic         in_accept;
  logic         out_take;
  logic         cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  mvp_decode u_decode (
    .midi_byte       (midi_byte),
    .state           (state),
    .listen_channel  (listen_channel),
    .realtime_enable (realtime_enable),
    .voice_enable    (voice_enable),
    .state_next      (state_next),
    .result          (result),
    .result_hit      (result_hit)
  );

  always_comb begin
    unique case (paddr[3:2])
      RegListenChannel:  prdata = {27'd0, listen_channel};
      RegRealtimeEnable: prdata = {24'd0, realtime_enable};
      RegVoiceEnable:    prdata = {25'd0, voice_enable};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    state_load = state;
    if (in_accept) begin
      state_load = state_next;
    end
    if (cfg_write && paddr[3:2] == RegListenChannel) begin
      state_load.running_status = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel  <= OmniChannel;
      realtime_enable <= '0;
      voice_enable    <= '0;
      state           <= '0;
    end else begin
      state <= state_load;
      if (cfg_write) begin
        unique case (paddr[3:2])
          RegListenChannel:  listen_channel  <= pwdata[4:0];
          RegRealtimeEnable: realtime_enable <= pwdata[7:0];
          RegVoiceEnable:    voice_enable    <= pwdata[6:0];
          default:           listen_channel  <= listen_channel;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_accept && result_hit) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_accept && result_hit) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

  assign is_voice    = out_data.is_voice;
  assign msg_type    = out_data.msg_type;
  assign msg_channel = out_data.msg_channel;
  assign first_data  = out_data.first_data;
  assign second_data = out_data.second_data;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an event while the output register is empty");

  a_listen_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && paddr[3:2] == RegListenChannel) |=> state.running_status == 8'd0)
    else $error("listen channel write did not clear the running status");

  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    state.running_status != 8'd0 |->
      (state.bytes_remaining == 2'd1 || state.bytes_remaining == 2'd2))
    else $error("data byte count out of range under running status");

  a_voice_channel: assert property (@(posedge clk) disable iff (rst)
    (in_accept && result_hit && result.is_voice && listen_channel != OmniChannel)
      |-> {1'b0, result.msg_channel} == listen_channel)
    else $error("voice event produced for a channel that is not listened to");

endmodule
